### hw/rtl/incremental_pid_motor_drive_assert.svh
// Assertion macros for the PID motor drive RTL.
// No dependencies; included by the top level after its declarations.
`ifndef INCREMENTAL_PID_MOTOR_DRIVE_ASSERT_SVH
`define INCREMENTAL_PID_MOTOR_DRIVE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define IPMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ipmd_pkg.sv
// Package for the incremental PID motor drive: register map, reset values,
// action codes and the structs passed between top level and step core.
package ipmd_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TARGET_ANGLE = 3'd0,
		REG_GAIN_P       = 3'd1,
		REG_GAIN_I       = 3'd2,
		REG_GAIN_D       = 3'd3,
		REG_MAX_DRIVE    = 3'd4,
		REG_TILT_LIMIT   = 3'd5,
		REG_MIN_DUTY     = 3'd6,
		REG_BOOST_FLOOR  = 3'd7
	} cfg_reg_t;

	// result action codes
	typedef enum logic [1:0] {
		ACT_DRIVE = 2'd0,
		ACT_HOLD  = 2'd1,
		ACT_TILT  = 2'd2
	} action_t;

	// register reset values
	localparam logic signed [15:0] RST_TARGET_ANGLE = -16'sd512;
	localparam logic [15:0]        RST_GAIN_P       = 16'd6400;
	localparam logic [15:0]        RST_GAIN_I       = 16'd538;
	localparam logic [15:0]        RST_GAIN_D       = 16'd30720;
	localparam logic [7:0]         RST_MAX_DRIVE    = 8'd255;
	localparam logic [14:0]        RST_TILT_LIMIT   = 15'd7680;
	localparam logic [7:0]         RST_MIN_DUTY     = 8'd70;
	localparam logic [7:0]         RST_BOOST_FLOOR  = 8'd10;

	typedef struct packed {
		logic signed [15:0] target_angle;
		logic [15:0]        gain_p;
		logic [15:0]        gain_i;
		logic [15:0]        gain_d;
		logic [7:0]         max_drive;
		logic [14:0]        tilt_limit;
		logic [7:0]         min_duty;
		logic [7:0]         boost_floor;
	} cfg_t;

	// one result item
	typedef struct packed {
		action_t    action;
		logic       forward;
		logic [7:0] duty;
	} res_t;

	// drive currently held by the core
	typedef struct packed {
		logic       forward;
		logic [7:0] duty;
	} held_t;

endpackage

### hw/rtl/ipmd_step_core.sv
// One incremental PID step with drive decode, plus the controller history.
// Depends on ipmd_pkg.
module ipmd_step_core
	import ipmd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,       // commit this item's state update
	input  logic signed [15:0] tilt_angle,
	input  cfg_t               cfg,
	output res_t               res,        // result for the current item
	output held_t              held        // held drive before this item
);

	logic signed [17:0] err_last_q;
	logic signed [17:0] err_before_last_q;
	logic signed [17:0] drive_accum_q;
	held_t              held_q;

	logic signed [16:0] ang_x;
	logic signed [16:0] ang_neg;
	logic [16:0]        mag;
	logic               tilted;
	logic signed [17:0] err;
	logic signed [18:0] d_p;
	logic signed [18:0] d_i;
	logic signed [20:0] d_d;
	logic signed [16:0] g_p;
	logic signed [16:0] g_i;
	logic signed [16:0] g_d;
	logic signed [35:0] prod_p;
	logic signed [35:0] prod_i;
	logic signed [35:0] prod_d;
	logic signed [29:0] sum;
	logic signed [29:0] lim;
	logic signed [17:0] outv;
	logic signed [17:0] outv_neg;
	logic signed [17:0] md_s;
	logic signed [17:0] bf_s;
	logic [7:0]         new_duty;
	logic               new_fwd;

	// tilt check on angle magnitude
	assign ang_x   = {tilt_angle[15], tilt_angle};
	assign ang_neg = -ang_x;
	assign mag     = tilt_angle[15] ? $unsigned(ang_neg) : $unsigned(ang_x);
	assign tilted  = !(mag < {2'b00, cfg.tilt_limit});

	// error and its differences
	assign err = {{2{cfg.target_angle[15]}}, cfg.target_angle}
		- {{2{tilt_angle[15]}}, tilt_angle};
	assign d_p = {err[17], err} - {err_last_q[17], err_last_q};
	assign d_i = {err[17], err} + {err_last_q[17], err_last_q};
	assign d_d = {{3{err[17]}}, err}
		- {{2{err_last_q[17]}}, err_last_q, 1'b0}
		+ {{3{err_before_last_q[17]}}, err_before_last_q};

	// gain products, three in parallel
	assign g_p    = $signed({1'b0, cfg.gain_p});
	assign g_i    = $signed({1'b0, cfg.gain_i});
	assign g_d    = $signed({1'b0, cfg.gain_d});
	assign prod_p = g_p * d_p;
	assign prod_i = g_i * d_i;
	assign prod_d = g_d * d_d;

	// dropping the low byte is a floor shift by 8
	assign sum = {{12{drive_accum_q[17]}}, drive_accum_q}
		+ {{2{prod_p[35]}}, prod_p[35:8]}
		+ {{2{prod_i[35]}}, prod_i[35:8]}
		+ {{2{prod_d[35]}}, prod_d[35:8]};

	// clamp to +/- max_drive
	assign lim = $signed({14'd0, cfg.max_drive, 8'd0});
	always_comb begin
		if (sum > lim) begin
			outv = lim[17:0];
		end else if (sum < -lim) begin
			outv = 18'(-lim);
		end else begin
			outv = sum[17:0];
		end
	end

	// drive decode with deadband boost
	assign outv_neg = -outv;
	assign md_s     = $signed({2'b00, cfg.min_duty, 8'd0});
	assign bf_s     = $signed({2'b00, cfg.boost_floor, 8'd0});
	always_comb begin
		new_fwd = !outv[17];
		if (!outv[17]) begin
			if (outv > bf_s && outv < md_s) begin
				new_duty = cfg.min_duty;
			end else begin
				new_duty = outv[15:8];
			end
		end else begin
			if (outv > -md_s) begin
				new_duty = cfg.min_duty;
			end else begin
				new_duty = outv_neg[15:8];
			end
		end
	end

	// result for this item
	always_comb begin
		if (tilted) begin
			res.action  = ACT_TILT;
			res.forward = 1'b0;
			res.duty    = 8'd0;
		end else if (outv == '0) begin
			res.action  = ACT_HOLD;
			res.forward = held_q.forward;
			res.duty    = held_q.duty;
		end else begin
			res.action  = ACT_DRIVE;
			res.forward = new_fwd;
			res.duty    = new_duty;
		end
	end

	assign held = held_q;

	// controller history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_last_q        <= '0;
			err_before_last_q <= '0;
			drive_accum_q     <= '0;
			held_q            <= '0;
		end else if (step) begin
			err_before_last_q <= err_last_q;
			if (tilted) begin
				held_q <= '0;
			end else begin
				err_last_q    <= err;
				drive_accum_q <= outv;
				if (outv != '0) begin
					held_q.duty    <= new_duty;
					held_q.forward <= new_fwd;
				end
			end
		end
	end

endmodule

### hw/rtl/incremental_pid_motor_drive.sv
// Top level of the incremental PID motor drive: stream ports, config
// registers, input and result registers. Depends on ipmd_pkg, ipmd_step_core.
//
// Usage:
//  - s_axis carries one tilt angle per request (signed Q8.8 degrees).
//  - m_axis returns exactly one result per request: duty, direction and an
//    action code (drive, hold previous drive, stopped by tilt).
//  - cfg_we/cfg_index/cfg_wdata write the eight setup registers; write them
//    only while no request is in flight.
// Path: an accepted request sits in the input register; the PID step runs in
// one pass from there into the result register, which raises m_axis_tvalid.
// Throughput: one request per cycle unless stalled; the PID history feedback
// closes in that one pass, so back-to-back requests see each other's state.
// Reset: registers take their default setup, history and held drive clear,
// both channels come up empty.
// Stall: a result waits in the result register while m_axis_tready is low;
// one more request may sit in the input register, after which s_axis_tready
// drops until the result is taken.
module incremental_pid_motor_drive
	import ipmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] tilt_angle
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] duty, [8] forward, [10:9] action
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t               cfg_q;
	logic               valid_s1;
	logic signed [15:0] angle_s1;
	logic               out_valid_q;
	res_t               res_q;
	res_t               res;
	held_t              held;
	logic               advance;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_angle <= RST_TARGET_ANGLE;
			cfg_q.gain_p       <= RST_GAIN_P;
			cfg_q.gain_i       <= RST_GAIN_I;
			cfg_q.gain_d       <= RST_GAIN_D;
			cfg_q.max_drive    <= RST_MAX_DRIVE;
			cfg_q.tilt_limit   <= RST_TILT_LIMIT;
			cfg_q.min_duty     <= RST_MIN_DUTY;
			cfg_q.boost_floor  <= RST_BOOST_FLOOR;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_ANGLE: cfg_q.target_angle <= $signed(cfg_wdata);
				REG_GAIN_P:       cfg_q.gain_p       <= cfg_wdata;
				REG_GAIN_I:       cfg_q.gain_i       <= cfg_wdata;
				REG_GAIN_D:       cfg_q.gain_d       <= cfg_wdata;
				REG_MAX_DRIVE:    cfg_q.max_drive    <= cfg_wdata[7:0];
				REG_TILT_LIMIT:   cfg_q.tilt_limit   <= cfg_wdata[14:0];
				REG_MIN_DUTY:     cfg_q.min_duty     <= cfg_wdata[7:0];
				REG_BOOST_FLOOR:  cfg_q.boost_floor  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result register is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			angle_s1 <= $signed(s_axis_tdata);
		end
	end

	// PID step and history
	ipmd_step_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.tilt_angle (angle_s1),
		.cfg        (cfg_q),
		.res        (res),
		.held       (held)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, res_q.action, res_q.forward, res_q.duty};

	// checks
`include "incremental_pid_motor_drive_assert.svh"

	`IPMD_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(angle_s1), "stalled input register changed")
	`IPMD_ASSERT_NEXT(a_step_gives_result, clk, arst_n, advance,
		out_valid_q, "committed step produced no result")
	`IPMD_ASSERT_NOW(a_result_matches_held, clk, arst_n, out_valid_q,
		res_q.duty == held.duty && res_q.forward == held.forward,
		"pending result disagrees with held drive")

endmodule
